### rtl/core/led_fx_pkg.sv
// ----------------------------------------------------------------------------
// led_fx_pkg: shared types and constants of the rgb led effect generator
// register map, effect codes, field widths and the raised cosine generator
// used to build the breathing rom at elaboration
// ----------------------------------------------------------------------------
package led_fx_pkg;

  // field widths
  localparam int LEVEL_W  = 8;
  localparam int PERIOD_W = 16;
  localparam int DUTY_W   = 8;
  localparam int COS_W    = 16;
  localparam int NOW_W    = 32;
  localparam int ACC_W    = LEVEL_W + COS_W;

  // effect codes
  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_BREATHE = 2'd2,
    MODE_RAINBOW = 2'd3
  } fx_mode_t;

  // input item kinds
  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_ENABLE  = 3'd1;
  localparam logic [2:0] REG_RED     = 3'd2;
  localparam logic [2:0] REG_GREEN   = 3'd3;
  localparam logic [2:0] REG_BLUE    = 3'd4;
  localparam logic [2:0] REG_BLINK   = 3'd5;
  localparam logic [2:0] REG_BREATHE = 3'd6;
  localparam logic [2:0] REG_RAINBOW = 3'd7;

  // period reset values
  localparam logic [PERIOD_W-1:0] BLINK_RST   = 16'd500;
  localparam logic [PERIOD_W-1:0] BREATHE_RST = 16'd2000;
  localparam logic [PERIOD_W-1:0] RAINBOW_RST = 16'd3000;

  // hue phase: 6 sectors of 256 steps, scaled as e*3 then 9 quotient bits
  localparam int HUE_W        = 11;
  localparam int HUE_FRAC_W   = 9;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam longint Q30_ONE = longint'(1) << 30;

  // cos(x) in q30 for 0 <= x <= pi/2, taylor series up to x^14
  function automatic longint cos_q30(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = Q30_ONE;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 2;
        2: term = term / 12;
        3: term = term / 30;
        4: term = term / 56;
        5: term = term / 90;
        6: term = term / 132;
        default: term = term / 182;
      endcase
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum > Q30_ONE) sum = Q30_ONE;
    if (sum < 0) sum = 0;
    return sum;
  endfunction

  // raised cosine entry i of a table with 2^pb entries, q1.15
  function automatic logic [COS_W-1:0] cos_entry(int unsigned pb, int unsigned i);
    int unsigned n;
    int unsigned half;
    int unsigned quarter;
    int unsigned j;
    longint      c;
    longint      v;
    n       = 1 << pb;
    half    = n >> 1;
    quarter = n >> 2;
    j       = (i <= half) ? i : n - i;
    if (j <= quarter) c = cos_q30((PI_Q30 * 64'(j)) >> (pb - 1));
    else              c = -cos_q30((PI_Q30 * 64'(half - j)) >> (pb - 1));
    v = ((Q30_ONE - c) + (longint'(1) << 15)) >>> 16;
    return COS_W'(v);
  endfunction

endpackage

### rtl/core/led_fx_rom.sv
// ----------------------------------------------------------------------------
// led_fx_rom: raised cosine rom
// 2^PHASE_BITS entries of q1.15, contents built at elaboration, registered read
// ----------------------------------------------------------------------------
module led_fx_rom
  import led_fx_pkg::*;
#(
  parameter int PHASE_BITS = 10
) (
  input  logic                  clk,
  input  logic [PHASE_BITS-1:0] addr,
  output logic [COS_W-1:0]      data
);

  localparam int DEPTH = 1 << PHASE_BITS;

  typedef logic [COS_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < DEPTH; i++) begin
      rom[i] = cos_entry(PHASE_BITS, i);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  // registered read port
  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

### rtl/core/rgb_led_effect_generator.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_generator: static, blink, breathing and rainbow led effects
// sequence: disabled or static go straight to the output register; blink after
//   the bit-serial modulo loop; rainbow adds the reduction, divide and hue map;
//   breathing adds the divide, the rom read and the 8-step serial multiply
// throughput: one item at a time, next item taken once the result is parked
//   in the output register; a restart item is taken in idle and gives no result
// reset: synchronous, clears start time and registers to their reset values
// ----------------------------------------------------------------------------
module rgb_led_effect_generator
  import led_fx_pkg::*;
#(
  parameter int PHASE_BITS = 10,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
  input  logic        s_axis_tuser,   // [0] kind
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(TIME_WIDTH);
  localparam int QW    = (PHASE_BITS > HUE_W) ? PHASE_BITS : HUE_W;
  localparam int REM_W = PERIOD_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_RED, ST_DIV, ST_HUE, ST_ROM, ST_MUL, ST_OUT
  } state_t;

  // configuration registers
  fx_mode_t            mode;
  logic                enable;
  logic [LEVEL_W-1:0]  red_level;
  logic [LEVEL_W-1:0]  green_level;
  logic [LEVEL_W-1:0]  blue_level;
  logic [PERIOD_W-1:0] blink_len;
  logic [PERIOD_W-1:0] breathe_period;
  logic [PERIOD_W-1:0] hue_len;

  // datapath
  state_t                state;
  logic [TIME_WIDTH-1:0] start_time;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [REM_W-1:0]      rem;
  logic [QW-1:0]         quot;
  logic [CNT_W-1:0]      cnt;
  logic [LEVEL_W-1:0]    lvl_r, lvl_g, lvl_b;
  logic [ACC_W-1:0]      acc_r, acc_g, acc_b;
  logic [DUTY_W-1:0]     res_r, res_g, res_b;
  logic [COS_W-1:0]      cos_val;

  logic                  cfg_wr;
  logic                  in_acc;
  logic                  out_load;
  logic [PERIOD_W-1:0]   per_sel;
  logic [REM_W-1:0]      per;
  logic                  div_in;
  logic [REM_W-1:0]      rem_sh;
  logic                  div_ge;
  logic [REM_W-1:0]      rem_div;
  logic                  red_ge;
  logic                  lit;
  logic [DUTY_W-1:0]     hue_f;
  logic [DUTY_W-1:0]     rise;
  logic [DUTY_W-1:0]     fall;
  logic [DUTY_W-1:0]     hue_r, hue_g, hue_b;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_MODE:    prdata = {30'd0, mode};
      REG_ENABLE:  prdata = {31'd0, enable};
      REG_RED:     prdata = {24'd0, red_level};
      REG_GREEN:   prdata = {24'd0, green_level};
      REG_BLUE:    prdata = {24'd0, blue_level};
      REG_BLINK:   prdata = {16'd0, blink_len};
      REG_BREATHE: prdata = {16'd0, breathe_period};
      REG_RAINBOW: prdata = {16'd0, hue_len};
      default:     prdata = 32'd0;
    endcase
  end

  // active period, zero read as one
  always_comb begin
    case (mode)
      MODE_BLINK:   per_sel = blink_len;
      MODE_BREATHE: per_sel = breathe_period;
      default:      per_sel = hue_len;
    endcase
    per = (per_sel == '0) ? REM_W'(1) : {2'b00, per_sel};
  end

  // one restoring divide step: modulo shifts in elapsed bits, quotient zeros
  assign div_in  = (state == ST_MOD) ? elapsed[TIME_WIDTH-1] : 1'b0;
  assign rem_sh  = {rem[REM_W-2:0], div_in};
  assign div_ge  = (rem_sh >= per);
  assign rem_div = div_ge ? (rem_sh - per) : rem_sh;
  assign red_ge  = (rem >= per);
  assign lit     = (rem_div < {3'b000, per[PERIOD_W-1:1]});

  // hue sector mapping
  assign hue_f = quot[DUTY_W-1:0];
  assign rise  = (hue_f == '0) ? '0 : hue_f - DUTY_W'(1);
  assign fall  = ~hue_f;
  always_comb begin
    case (quot[HUE_W-1:DUTY_W])
      3'd0:    begin hue_r = 8'hff; hue_g = rise;  hue_b = 8'h00; end
      3'd1:    begin hue_r = fall;  hue_g = 8'hff; hue_b = 8'h00; end
      3'd2:    begin hue_r = 8'h00; hue_g = 8'hff; hue_b = rise;  end
      3'd3:    begin hue_r = 8'h00; hue_g = fall;  hue_b = 8'hff; end
      3'd4:    begin hue_r = rise;  hue_g = 8'h00; hue_b = 8'hff; end
      default: begin hue_r = 8'hff; hue_g = 8'h00; hue_b = fall;  end
    endcase
  end

  led_fx_rom #(
    .PHASE_BITS(PHASE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (quot[PHASE_BITS-1:0]),
    .data (cos_val)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_STATIC;
      enable         <= 1'b0;
      red_level      <= '0;
      green_level    <= '0;
      blue_level     <= '0;
      blink_len      <= BLINK_RST;
      breathe_period <= BREATHE_RST;
      hue_len        <= RAINBOW_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE:    mode           <= fx_mode_t'(pwdata[1:0]);
        REG_ENABLE:  enable         <= pwdata[0];
        REG_RED:     red_level      <= pwdata[7:0];
        REG_GREEN:   green_level    <= pwdata[7:0];
        REG_BLUE:    blue_level     <= pwdata[7:0];
        REG_BLINK:   blink_len      <= pwdata[15:0];
        REG_BREATHE: breathe_period <= pwdata[15:0];
        REG_RAINBOW: hue_len        <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      start_time    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == KIND_RESTART) begin
              start_time <= s_axis_tdata[TIME_WIDTH-1:0];
            end else if (!enable) begin
              res_r <= '0;
              res_g <= '0;
              res_b <= '0;
              state <= ST_OUT;
            end else if (mode == MODE_STATIC) begin
              res_r <= red_level;
              res_g <= green_level;
              res_b <= blue_level;
              state <= ST_OUT;
            end else begin
              elapsed <= s_axis_tdata[TIME_WIDTH-1:0] - start_time;
              rem     <= '0;
              cnt     <= CNT_W'(TIME_WIDTH - 1);
              state   <= ST_MOD;
            end
          end
        end
        // elapsed mod period, one bit a cycle
        ST_MOD: begin
          elapsed <= {elapsed[TIME_WIDTH-2:0], 1'b0};
          if (cnt != '0) begin
            rem <= rem_div;
            cnt <= cnt - CNT_W'(1);
          end else begin
            quot <= '0;
            case (mode)
              MODE_BLINK: begin
                res_r <= lit ? red_level : '0;
                res_g <= lit ? green_level : '0;
                res_b <= lit ? blue_level : '0;
                state <= ST_OUT;
              end
              MODE_BREATHE: begin
                rem   <= rem_div;
                cnt   <= CNT_W'(PHASE_BITS - 1);
                state <= ST_DIV;
              end
              default: begin
                rem   <= {rem_div[REM_W-2:0], 1'b0} + rem_div;
                cnt   <= CNT_W'(1);
                state <= ST_RED;
              end
            endcase
          end
        end
        // integer part of 3*e/period, at most two subtractions
        ST_RED: begin
          if (red_ge) begin
            rem  <= rem - per;
            quot <= quot + QW'(1);
          end
          if (cnt == '0) begin
            cnt   <= CNT_W'(HUE_FRAC_W - 1);
            state <= ST_DIV;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        // quotient bits of the phase
        ST_DIV: begin
          rem  <= rem_div;
          quot <= {quot[QW-2:0], div_ge};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) state <= (mode == MODE_BREATHE) ? ST_ROM : ST_HUE;
        end
        ST_HUE: begin
          res_r <= hue_r;
          res_g <= hue_g;
          res_b <= hue_b;
          state <= ST_OUT;
        end
        // rom address presented, start serial multiply
        ST_ROM: begin
          lvl_r <= red_level;
          lvl_g <= green_level;
          lvl_b <= blue_level;
          acc_r <= '0;
          acc_g <= '0;
          acc_b <= '0;
          cnt   <= CNT_W'(LEVEL_W - 1);
          state <= ST_MUL;
        end
        // level times cosine, msb first shift and add
        ST_MUL: begin
          acc_r <= {acc_r[ACC_W-2:0], 1'b0} + (lvl_r[LEVEL_W-1] ? ACC_W'(cos_val) : '0);
          acc_g <= {acc_g[ACC_W-2:0], 1'b0} + (lvl_g[LEVEL_W-1] ? ACC_W'(cos_val) : '0);
          acc_b <= {acc_b[ACC_W-2:0], 1'b0} + (lvl_b[LEVEL_W-1] ? ACC_W'(cos_val) : '0);
          lvl_r <= {lvl_r[LEVEL_W-2:0], 1'b0};
          lvl_g <= {lvl_g[LEVEL_W-2:0], 1'b0};
          lvl_b <= {lvl_b[LEVEL_W-2:0], 1'b0};
          cnt   <= cnt - CNT_W'(1);
          if (cnt == '0) state <= ST_OUT;
        end
        // park the result once the output register is free
        ST_OUT: begin
          if (out_load) begin
            if (mode == MODE_BREATHE && enable) begin
              m_axis_tdata <= {acc_b[ACC_W-2:COS_W-1], acc_g[ACC_W-2:COS_W-1],
                               acc_r[ACC_W-2:COS_W-1]};
            end else begin
              m_axis_tdata <= {res_b, res_g, res_r};
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_mul_only_breathe: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> mode == MODE_BREATHE && enable)
    else $error("serial multiply outside breathing effect");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_HUE |-> quot[HUE_W-1:0] < 11'd1536)
    else $error("hue phase out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < per)
    else $error("divider remainder not below period");

  a_disabled_dark: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && !enable |-> res_r == '0 && res_g == '0 && res_b == '0)
    else $error("disabled led gives nonzero duty");

endmodule

### test/led_fx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_fx_checker: in-order scoreboard for the rgb led effect generator
// tracks the register file from apb writes and the effect start from restart
// items, works out the duty values of every accepted update item and compares
// each result item with the oldest one waiting; apb read data is checked
// against the tracked registers
// ----------------------------------------------------------------------------
module led_fx_checker
  import led_fx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
  input  logic        s_axis_tuser,   // [0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          pending,
  output int          mismatches
);

  localparam int ROM_BITS = 10;
  localparam int ROM_SIZE = 1 << ROM_BITS;
  localparam longint unsigned PI_Q30_V = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1 << 30;

  // hue sectors of the rainbow sweep, the last one (magenta to red) is the default
  typedef enum int {
    SECT_RED_YELLOW   = 0,
    SECT_YELLOW_GREEN = 1,
    SECT_GREEN_CYAN   = 2,
    SECT_CYAN_BLUE    = 3,
    SECT_BLUE_MAGENTA = 4
  } hue_sector_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } duty_t;

  // tracked registers and effect start
  fx_mode_t    fx_mode    = MODE_STATIC;
  logic        led_on     = 1'b0;
  logic [7:0]  lvl_r      = '0;
  logic [7:0]  lvl_g      = '0;
  logic [7:0]  lvl_b      = '0;
  logic [15:0] blink_ms   = BLINK_RST;
  logic [15:0] breathe_ms = BREATHE_RST;
  logic [15:0] rainbow_ms = RAINBOW_RST;
  logic [31:0] t_start    = '0;
  logic [15:0] cos_rom [ROM_SIZE];

  duty_t colour_q [$];
  int    bad_total = 0;

  // cosine in q30 by taylor series up to x^14, 0 <= x <= pi/2
  function automatic longint taylor_cos(longint unsigned x);
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    sq   = (x * x) >> 30;
    term = ONE_Q30;
    acc  = ONE_Q30;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * sq) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    if (acc > ONE_Q30) acc = ONE_Q30;
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  // q1.15 raised cosine, (1 - cos(2 pi i / N)) / 2 rounded
  function automatic logic [15:0] raised_cos(int unsigned i);
    int unsigned j;
    longint      c;
    longint      v;
    j = (i <= ROM_SIZE / 2) ? i : ROM_SIZE - i;
    if (j <= ROM_SIZE / 4) c = taylor_cos((PI_Q30_V * j) >> (ROM_BITS - 1));
    else c = -taylor_cos((PI_Q30_V * (ROM_SIZE / 2 - j)) >> (ROM_BITS - 1));
    v = ((ONE_Q30 - c) + 64'sd32768) >>> 16;
    return v[15:0];
  endfunction

  initial begin
    for (int i = 0; i < ROM_SIZE; i++) cos_rom[i] = raised_cos(i);
  end

  // duty values for an update item at time now
  function automatic duty_t led_colour(logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] per;
    logic [31:0] phase;
    logic [31:0] sector;
    logic [31:0] rise;
    logic [31:0] fall;
    logic [15:0] k;
    duty_t       d;
    d       = '0;
    elapsed = now - t_start;
    if (!led_on) return d;
    case (fx_mode)
      MODE_STATIC: begin
        d.red = lvl_r; d.green = lvl_g; d.blue = lvl_b;
      end
      MODE_BLINK: begin
        per = (blink_ms == 0) ? 32'd1 : 32'(blink_ms);
        if (elapsed % per < per / 2) begin
          d.red = lvl_r; d.green = lvl_g; d.blue = lvl_b;
        end
      end
      MODE_BREATHE: begin
        per   = (breathe_ms == 0) ? 32'd1 : 32'(breathe_ms);
        phase = ((elapsed % per) << ROM_BITS) / per;
        k     = cos_rom[phase[ROM_BITS-1:0]];
        d.red   = 8'((32'(lvl_r) * k) >> 15);
        d.green = 8'((32'(lvl_g) * k) >> 15);
        d.blue  = 8'((32'(lvl_b) * k) >> 15);
      end
      default: begin
        per    = (rainbow_ms == 0) ? 32'd1 : 32'(rainbow_ms);
        phase  = ((elapsed % per) * 32'd1536) / per;
        sector = phase >> 8;
        rise   = ((phase & 32'hFF) * 32'd255) >> 8;
        fall   = ((32'd256 - (phase & 32'hFF)) * 32'd255) >> 8;
        case (sector)
          SECT_RED_YELLOW: begin
            d.red = 8'd255; d.green = rise[7:0];
          end
          SECT_YELLOW_GREEN: begin
            d.red = fall[7:0]; d.green = 8'd255;
          end
          SECT_GREEN_CYAN: begin
            d.green = 8'd255; d.blue = rise[7:0];
          end
          SECT_CYAN_BLUE: begin
            d.green = fall[7:0]; d.blue = 8'd255;
          end
          SECT_BLUE_MAGENTA: begin
            d.red = rise[7:0]; d.blue = 8'd255;
          end
          default: begin
            d.red = 8'd255; d.blue = fall[7:0];
          end
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic logic [31:0] reg_readback(logic [2:0] idx);
    case (idx)
      REG_MODE:    return 32'(fx_mode);
      REG_ENABLE:  return 32'(led_on);
      REG_RED:     return 32'(lvl_r);
      REG_GREEN:   return 32'(lvl_g);
      REG_BLUE:    return 32'(lvl_b);
      REG_BLINK:   return 32'(blink_ms);
      REG_BREATHE: return 32'(breathe_ms);
      default:     return 32'(rainbow_ms);
    endcase
  endfunction

  task automatic check_value(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      bad_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    duty_t want;
    duty_t got;
    if (rst) begin
      fx_mode    = MODE_STATIC;
      led_on     = 1'b0;
      lvl_r      = '0;
      lvl_g      = '0;
      lvl_b      = '0;
      blink_ms   = BLINK_RST;
      breathe_ms = BREATHE_RST;
      rainbow_ms = RAINBOW_RST;
      t_start    = '0;
      colour_q.delete();
    end else begin
      // result items against the oldest colour waiting
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got = m_axis_tdata;
        if (colour_q.size() == 0) begin
          $error("result item %h with no colour pending", m_axis_tdata);
          bad_total++;
        end else begin
          want = colour_q.pop_front();
          check_value("red_duty", want.red, got.red);
          check_value("green_duty", want.green, got.green);
          check_value("blue_duty", want.blue, got.blue);
        end
      end
      // input items: restart moves the start, update predicts a colour
      if (s_axis_tvalid && s_axis_tready === 1'b1) begin
        if (s_axis_tuser == KIND_RESTART) t_start = s_axis_tdata;
        else colour_q.push_back(led_colour(s_axis_tdata));
      end
      // register writes and reads
      if (psel && penable && pready === 1'b1) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_MODE:    fx_mode    = fx_mode_t'(pwdata[1:0]);
            REG_ENABLE:  led_on     = pwdata[0];
            REG_RED:     lvl_r      = pwdata[7:0];
            REG_GREEN:   lvl_g      = pwdata[7:0];
            REG_BLUE:    lvl_b      = pwdata[7:0];
            REG_BLINK:   blink_ms   = pwdata[15:0];
            REG_BREATHE: breathe_ms = pwdata[15:0];
            default:     rainbow_ms = pwdata[15:0];
          endcase
        end else begin
          check_value("prdata", reg_readback(paddr[4:2]), prdata);
        end
      end
    end
    pending    <= colour_q.size();
    mismatches <= bad_total;
  end

endmodule

### test/tb_rgb_led_effect_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_led_effect_generator: stimulus and verdict for the led effect block
// directed items over every effect, the wrap of the timestamp and the zero
// and one periods, then random phases with new register settings, random
// handshake gaps on both sides and a long output hold-off
// ----------------------------------------------------------------------------
module tb_rgb_led_effect_generator;
  import led_fx_pkg::*;

  localparam logic APB_READ  = 1'b0;
  localparam logic APB_WRITE = 1'b1;
  localparam int   NUM_REGS  = 8;
  localparam int   PHASES    = 8;
  localparam int   PHASE_ITEMS = 100;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] now_ms
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int          mismatches;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 45;
  bit          stall_req = 1'b0;
  logic [31:0] last_start = '0;

  rgb_led_effect_generator dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  led_fx_checker score (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pending, .mismatches
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random ready, or a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one item, returns at the edge where it is taken
  task automatic send_item(input logic kind, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= now;
    if (kind == KIND_RESTART) last_start = now;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drain all results, then let the block finish any item in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // one apb transfer, random bits above the register width
  task automatic apb_xfer(input logic wr, input logic [2:0] idx,
                          input logic [31:0] value, input int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom << width) | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all();
    for (int i = 0; i < NUM_REGS; i++) apb_xfer(APB_READ, 3'(i), '0, 0);
  endtask

  initial begin : stim
    int unsigned blink_pts[5]   = '{0, 4, 5, 9, 10};
    int unsigned breathe_pts[4] = '{0, 256, 512, 1023};
    int unsigned hue_pts[8]     = '{0, 255, 256, 511, 768, 1024, 1280, 1535};
    logic [15:0] blink_p;
    logic [15:0] breathe_p;
    logic [15:0] rainbow_p;
    logic [31:0] now;
    logic        kind;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_UPDATE;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values, then disabled update and a restart stored while off
    read_all();
    send_item(KIND_UPDATE, 32'h0000_0000);
    send_item(KIND_RESTART, 32'hFFFF_FFF0);

    // static colour across the timestamp wrap
    settle();
    apb_xfer(APB_WRITE, REG_ENABLE, 32'd1, 1);
    apb_xfer(APB_WRITE, REG_RED, 32'd255, 8);
    apb_xfer(APB_WRITE, REG_GREEN, 32'd0, 8);
    apb_xfer(APB_WRITE, REG_BLUE, 32'h5A, 8);
    send_item(KIND_UPDATE, 32'h0000_0005);

    // blink edges around half period
    settle();
    apb_xfer(APB_WRITE, REG_MODE, 32'(MODE_BLINK), 2);
    apb_xfer(APB_WRITE, REG_BLINK, 32'd10, 16);
    foreach (blink_pts[i]) send_item(KIND_UPDATE, last_start + blink_pts[i]);

    // zero period counts as one, and one period is always dark
    settle();
    apb_xfer(APB_WRITE, REG_BLINK, 32'd0, 16);
    send_item(KIND_UPDATE, $urandom);
    settle();
    apb_xfer(APB_WRITE, REG_BLINK, 32'd1, 16);
    send_item(KIND_UPDATE, $urandom);

    // breathing at trough, quarter, peak and end of cycle
    settle();
    apb_xfer(APB_WRITE, REG_MODE, 32'(MODE_BREATHE), 2);
    apb_xfer(APB_WRITE, REG_BREATHE, 32'd1024, 16);
    apb_xfer(APB_WRITE, REG_GREEN, 32'd255, 8);
    apb_xfer(APB_WRITE, REG_BLUE, 32'd255, 8);
    foreach (breathe_pts[i]) send_item(KIND_UPDATE, last_start + breathe_pts[i]);
    settle();
    apb_xfer(APB_WRITE, REG_BREATHE, 32'd0, 16);
    send_item(KIND_UPDATE, $urandom);

    // rainbow through five of the six hue sectors, all but green to cyan
    settle();
    apb_xfer(APB_WRITE, REG_MODE, 32'(MODE_RAINBOW), 2);
    apb_xfer(APB_WRITE, REG_RAINBOW, 32'd1536, 16);
    send_item(KIND_RESTART, 32'd0);
    foreach (hue_pts[i]) send_item(KIND_UPDATE, last_start + hue_pts[i]);

    // disabled forces zero in any effect
    settle();
    apb_xfer(APB_WRITE, REG_ENABLE, 32'd0, 1);
    send_item(KIND_UPDATE, 32'd700);

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 3) begin
        send_idle_pct = 16; recv_idle_pct = 45;
      end else if (ph < 6) begin
        send_idle_pct = 45; recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case (ph)
        1: begin
          blink_p = 16'hFFFF; breathe_p = 16'hFFFF; rainbow_p = 16'hFFFF;
        end
        2: begin
          blink_p = 16'd1; breathe_p = 16'd1; rainbow_p = 16'd1;
        end
        3: begin
          blink_p = 16'd0; breathe_p = 16'd0; rainbow_p = 16'd0;
        end
        4, 6: begin
          blink_p   = 16'($urandom_range(2, 40));
          breathe_p = 16'($urandom_range(2, 40));
          rainbow_p = 16'($urandom_range(2, 40));
        end
        5: begin
          blink_p   = 16'($urandom_range(1, 65535));
          breathe_p = 16'($urandom_range(1024, 65535));
          rainbow_p = 16'($urandom_range(1, 65535));
        end
        default: begin
          blink_p   = 16'($urandom_range(1, 65535));
          breathe_p = 16'($urandom_range(1, 65535));
          rainbow_p = 16'($urandom_range(1, 65535));
        end
      endcase
      apb_xfer(APB_WRITE, REG_MODE, 32'((ph + ph / 4) % 4), 2);
      apb_xfer(APB_WRITE, REG_ENABLE, 32'(ph != PHASES - 1), 1);
      apb_xfer(APB_WRITE, REG_RED, (ph == 1) ? 32'd255 : 32'($urandom_range(255)), 8);
      apb_xfer(APB_WRITE, REG_GREEN, (ph == 1) ? 32'd255 : 32'($urandom_range(255)), 8);
      apb_xfer(APB_WRITE, REG_BLUE, (ph == 1) ? 32'd255 : 32'($urandom_range(255)), 8);
      apb_xfer(APB_WRITE, REG_BLINK, 32'(blink_p), 16);
      apb_xfer(APB_WRITE, REG_BREATHE, 32'(breathe_p), 16);
      apb_xfer(APB_WRITE, REG_RAINBOW, 32'(rainbow_p), 16);
      read_all();

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long output hold-off while items keep coming
        if ((ph == 2 && i == 40) || (ph == 6 && i == 50)) stall_req = 1'b1;
        kind = ($urandom_range(99) < 15) ? KIND_RESTART : KIND_UPDATE;
        case ($urandom_range(3))
          0:       now = last_start + $urandom_range(0, 255);
          1:       now = last_start + $urandom_range(0, 262143);
          2:       now = last_start - $urandom_range(1, 255);
          default: now = $urandom;
        endcase
        send_item(kind, now);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
